### src/gbn_pkg.sv
package gbn_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int SEQ_W      = 32;
    localparam int WIN_W      = 7;
    localparam int TMO_W      = 16;
    localparam int CMD_W      = 2;
    localparam int KIND_W     = 2;
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);

    localparam logic [WIN_W-1:0] WINDOW_RESET  = WIN_W'(8);
    localparam logic [TMO_W-1:0] TIMEOUT_RESET = TMO_W'(20);
    localparam logic [SEQ_W-1:0] SEQ_RESET     = SEQ_W'(1);

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = TMO_W;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 1'b1;

    // input commands
    localparam logic [CMD_W-1:0] CMD_SEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_NEW     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RETX    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REFUSED = 2'd2;

    // job queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [WIN_W-1:0] window_size;
        logic [TMO_W-1:0] timeout_ticks;
    } cfg_t;

    // one job: a run of count results starting at start
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SEQ_W-1:0]  start;
        logic [CNT_W-1:0]  count;
        logic [SEQ_W-1:0]  base;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } push_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

### src/gbn_if.sv
interface gbn_in_if;
    logic                        valid;
    logic                        ready;
    logic [gbn_pkg::CMD_W-1:0]   cmd;
    logic [gbn_pkg::SEQ_W-1:0]   ack_number;

    modport source (output valid, output cmd, output ack_number, input ready);
    modport sink   (input valid, input cmd, input ack_number, output ready);
endinterface

interface gbn_out_if;
    logic                        valid;
    logic                        ready;
    logic [gbn_pkg::KIND_W-1:0]  kind;
    logic [gbn_pkg::SEQ_W-1:0]   seq_number;
    logic                        last;
    logic [gbn_pkg::SEQ_W-1:0]   window_base;

    modport source (output valid, output kind, output seq_number, output last,
                    output window_base, input ready);
    modport sink   (input valid, input kind, input seq_number, input last,
                    input window_base, output ready);
endinterface

### src/gbn_front.sv
module gbn_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  gbn_pkg::cfg_t             cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [gbn_pkg::CMD_W-1:0] in_cmd,
    input  logic [gbn_pkg::SEQ_W-1:0] in_ack,
    input  gbn_pkg::q_status_t        q_status,
    output gbn_pkg::push_t            push
);
    import gbn_pkg::*;

    logic [SEQ_W-1:0] base_seq_reg, base_seq_next;
    logic [SEQ_W-1:0] next_seq_reg, next_seq_next;
    logic             timer_running_reg, timer_running_next;
    logic [TMO_W-1:0] timer_count_reg, timer_count_next;

    logic [SEQ_W-1:0] diff;
    logic [SEQ_W-1:0] ack_off;
    logic [WIN_W-1:0] eff_win;
    logic [TMO_W-1:0] eff_tmo;
    logic             fire;
    logic             too_many;

    assign in_ready = !q_status.full;
    assign fire     = in_valid && in_ready;
    assign diff     = next_seq_reg - base_seq_reg;
    assign ack_off  = in_ack - base_seq_reg;
    assign too_many = diff > SEQ_W'(MAX_WINDOW);
    assign eff_tmo  = (cfg.timeout_ticks == '0) ? TMO_W'(1) : cfg.timeout_ticks;

    always_comb
    begin
        if (cfg.window_size == '0)
        begin
            eff_win = WIN_W'(1);
        end
        else if (cfg.window_size > WIN_W'(MAX_WINDOW))
        begin
            eff_win = WIN_W'(MAX_WINDOW);
        end
        else
        begin
            eff_win = cfg.window_size;
        end
    end

    always_comb
    begin
        base_seq_next      = base_seq_reg;
        next_seq_next      = next_seq_reg;
        timer_running_next = timer_running_reg;
        timer_count_next   = timer_count_reg;
        push.valid         = 1'b0;
        push.job.kind      = KIND_NEW;
        push.job.start     = next_seq_reg;
        push.job.count     = CNT_W'(1);
        push.job.base      = base_seq_reg;
        if (fire)
        begin
            case (in_cmd)
                CMD_SEND:
                begin
                    push.valid = 1'b1;
                    if (diff < SEQ_W'(eff_win))
                    begin
                        if (diff == '0)
                        begin
                            timer_running_next = 1'b1;
                            timer_count_next   = eff_tmo;
                        end
                        next_seq_next = next_seq_reg + SEQ_W'(1);
                    end
                    else
                    begin
                        push.job.kind = KIND_REFUSED;
                    end
                end
                CMD_ACK:
                begin
                    // acks outside the outstanding range are dropped
                    if (ack_off < diff)
                    begin
                        base_seq_next = in_ack + SEQ_W'(1);
                        if (base_seq_next == next_seq_reg)
                        begin
                            timer_running_next = 1'b0;
                            timer_count_next   = '0;
                        end
                        else
                        begin
                            timer_running_next = 1'b1;
                            timer_count_next   = eff_tmo;
                        end
                    end
                end
                CMD_TICK:
                begin
                    if (timer_running_reg)
                    begin
                        if (diff == '0 || too_many)
                        begin
                            timer_running_next = 1'b0;
                            timer_count_next   = '0;
                        end
                        else if (timer_count_reg > TMO_W'(1))
                        begin
                            timer_count_next = timer_count_reg - TMO_W'(1);
                        end
                        else
                        begin
                            timer_count_next = eff_tmo;
                            push.valid       = 1'b1;
                            push.job.kind    = KIND_RETX;
                            push.job.start   = base_seq_reg;
                            push.job.count   = diff[CNT_W-1:0];
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_seq_reg      <= SEQ_RESET;
            next_seq_reg      <= SEQ_RESET;
            timer_running_reg <= 1'b0;
            timer_count_reg   <= '0;
        end
        else
        begin
            base_seq_reg      <= base_seq_next;
            next_seq_reg      <= next_seq_next;
            timer_running_reg <= timer_running_next;
            timer_count_reg   <= timer_count_next;
        end
    end

    // window never holds more than the maximum number outstanding
    a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (next_seq_reg - base_seq_reg) <= SEQ_W'(MAX_WINDOW))
        else $error("outstanding count above maximum window");

    // timer runs exactly while something is outstanding
    a_timer_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        timer_running_reg == (next_seq_reg != base_seq_reg))
        else $error("timer state disagrees with outstanding count");

    // a running timer never sits at zero
    a_timer_count: assert property (@(posedge clk) disable iff (!rst_n)
        timer_running_reg |-> (timer_count_reg != '0))
        else $error("running timer with zero count");

endmodule

### src/gbn_queue.sv
module gbn_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  gbn_pkg::push_t     push,
    input  logic               pop,
    output gbn_pkg::job_t      head,
    output gbn_pkg::q_status_t status
);
    import gbn_pkg::*;

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign status.empty = (cnt_reg == '0);
    assign status.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign do_push      = push.valid && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push.job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### src/gbn_back.sv
module gbn_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  gbn_pkg::job_t              head,
    input  gbn_pkg::q_status_t         q_status,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [gbn_pkg::KIND_W-1:0] out_kind,
    output logic [gbn_pkg::SEQ_W-1:0]  out_seq,
    output logic                       out_last,
    output logic [gbn_pkg::SEQ_W-1:0]  out_base
);
    import gbn_pkg::*;

    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              valid_reg, valid_next;
    logic [KIND_W-1:0] kind_reg;
    logic [SEQ_W-1:0]  seq_reg;
    logic              last_reg;
    logic [SEQ_W-1:0]  base_reg;
    logic              load;
    logic              is_last;

    assign load    = (!valid_reg || out_ready) && !q_status.empty;
    assign is_last = (idx_reg + CNT_W'(1)) == head.count;
    assign pop     = load && is_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = is_last ? '0 : idx_reg + CNT_W'(1);
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= head.kind;
            seq_reg  <= head.start + SEQ_W'(idx_reg);
            last_reg <= is_last;
            base_reg <= head.base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_seq   = seq_reg;
    assign out_last  = last_reg;
    assign out_base  = base_reg;

endmodule

### src/go_back_n_sender_window.sv
// go-back-n sender window controller, sequence numbers only
// in_ch carries one transaction per command: send request, cumulative ack or
// timer tick (ack_number is looked at for acks only)
// out_ch carries the results: one transmit-new or refused result per send,
// nothing for an ack, and on timer expiry one retransmit result per
// outstanding number, base first, with last set on the final one
// every result also reports the window base after its command
// the command side takes one transaction a cycle while the job queue between
// the classifying front and the result back end has room; an accepted send
// is written into the job queue and then loaded into the output register
// the back end gives one result a cycle while the receiver takes them, so
// a retransmit run takes one output result per outstanding number (up to 64)
// when the receiver stalls, results wait in the output register and the
// queue fills; in_ch.ready then drops until a slot frees
// reset: base and next sequence number 1, timer stopped, window size 8,
// timeout 20 ticks, queue and output empty; the user alone must see that
// configuration is written through cfg_we/cfg_index/cfg_data while idle
module go_back_n_sender_window (
    input  logic                           clk,
    input  logic                           rst_n,
    gbn_in_if.sink                         in_ch,
    gbn_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [gbn_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gbn_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gbn_pkg::*;

    // configuration registers
    cfg_t      cfg_reg, cfg_next;

    // front to queue, queue to back
    push_t     push;
    job_t      head;
    q_status_t q_status;
    logic      pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_WINDOW_SIZE:   cfg_next.window_size   = cfg_data[WIN_W-1:0];
                REG_TIMEOUT_TICKS: cfg_next.timeout_ticks = cfg_data[TMO_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_size   <= WINDOW_RESET;
            cfg_reg.timeout_ticks <= TIMEOUT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: window state, timer and command classification
    gbn_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .in_cmd   (in_ch.cmd),
        .in_ack   (in_ch.ack_number),
        .q_status (q_status),
        .push     (push)
    );

    // short job queue decoupling the two sides
    gbn_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .head   (head),
        .status (q_status)
    );

    // back: expands each job into results, output register
    gbn_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_kind  (out_ch.kind),
        .out_seq   (out_ch.seq_number),
        .out_last  (out_ch.last),
        .out_base  (out_ch.window_base)
    );

endmodule
